// ===== rtl/light_link_frame_receiver_assert.svh =====
// Assertion macros for the light link frame receiver.
`ifndef LIGHT_LINK_FRAME_RECEIVER_ASSERT_SVH
`define LIGHT_LINK_FRAME_RECEIVER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define LLFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/llfr_pkg.sv =====
// Types and constants shared by the light link frame receiver files.
package llfr_pkg;

  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned ACC_W       = SIZE_W + 1;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [BYTE_W-1:0] MESSAGE_LIMIT = 8'd255;
  localparam logic [2:0]        BIT_POS_TOP   = 3'd7;
  localparam logic [ACC_W-1:0]  SIZE_SAT      = 17'd65536;
  localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_NINE    = 8'd57;

  localparam logic ACTION_START  = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FILE_MARKER        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_CEILING       = 3'd4;

  localparam logic [LEVEL_W-1:0] RESET_LIGHT_THRESHOLD    = 10'd512;
  localparam logic [BYTE_W-1:0]  RESET_END_MARKER         = 8'd0;
  localparam logic [BYTE_W-1:0]  RESET_FILE_MARKER        = 8'd35;
  localparam logic [BYTE_W-1:0]  RESET_MAX_MESSAGE_LENGTH = 8'd255;
  localparam logic [SIZE_W-1:0]  RESET_SIZE_CEILING       = 16'd1024;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MESSAGE = 2'd1,
    MODE_HEADER  = 2'd2,
    MODE_FILE    = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MSG_BYTE      = 3'd0,
    KIND_END_MARKER    = 3'd1,
    KIND_END_LIMIT     = 3'd2,
    KIND_HDR_ACCEPTED  = 3'd3,
    KIND_HDR_REJECTED  = 3'd4,
    KIND_FILE_BYTE     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [SIZE_W-1:0]  file_size;
    logic               last;
  } result_t;

endpackage

// ===== rtl/llfr_ifs.sv =====
// Handshake channel interfaces of the light link frame receiver.
interface llfr_sample_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [llfr_pkg::LEVEL_W-1:0]   light_level;

  modport source (output valid, output action, output light_level, input ready);
  modport sink   (input valid, input action, input light_level, output ready);
endinterface

interface llfr_result_if;
  logic                           valid;
  logic                           ready;
  logic [llfr_pkg::KIND_W-1:0]    kind;
  logic [llfr_pkg::BYTE_W-1:0]    data_byte;
  logic [llfr_pkg::SIZE_W-1:0]    file_size;
  logic                           last;

  modport source (output valid, output kind, output data_byte, output file_size,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input file_size,
                  input last, output ready);
endinterface

interface llfr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [llfr_pkg::CFG_INDEX_W-1:0]   index;
  logic [llfr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/light_link_frame_receiver.sv =====
// Light link frame receiver: on-off-keyed light samples in, message and file beats out.
// A result beat is registered from the sample beat that completes its byte into the output
// register (skid register if stalled); one sample beat per cycle while the skid is empty.
// A two-entry output stage (output register plus skid register) sets the rate: samples
// are taken while the skid register is empty, even if the output beat is stalled.
// Reset (synchronous, rst high) restores register defaults, idles the receiver, drops outputs.
module light_link_frame_receiver (
  input  logic              clk,
  input  logic              rst,
  llfr_cfg_if.sink          cfg,
  llfr_sample_if.sink       samples,
  llfr_result_if.source     results
);

  // Configuration registers
  logic [llfr_pkg::LEVEL_W-1:0] light_threshold;
  logic [llfr_pkg::BYTE_W-1:0]  end_marker;
  logic [llfr_pkg::BYTE_W-1:0]  file_marker;
  logic [llfr_pkg::BYTE_W-1:0]  max_message_length;
  logic [llfr_pkg::SIZE_W-1:0]  size_ceiling;

  // Frame state
  llfr_pkg::mode_t              mode, mode_next;
  logic [2:0]                   bit_pos, bit_pos_next;
  logic [llfr_pkg::BYTE_W-1:0]  byte_shift, byte_shift_next;
  logic [llfr_pkg::BYTE_W-1:0]  bytes_so_far, bytes_so_far_next;
  logic                         digits_active, digits_active_next;
  logic [llfr_pkg::ACC_W-1:0]   size_acc, size_acc_next;
  logic [llfr_pkg::SIZE_W-1:0]  file_left, file_left_next;

  // Output stage
  logic                         out_valid;
  llfr_pkg::result_t            out_reg;
  logic                         skid_valid;
  llfr_pkg::result_t            skid_reg;

  // Per-beat working signals
  logic                         sample_fire;
  logic                         sample_bit;
  logic [llfr_pkg::BYTE_W-1:0]  shifted;
  logic [llfr_pkg::BYTE_W-1:0]  lim;
  logic [llfr_pkg::BYTE_W-1:0]  bytes_inc;
  logic                         is_digit;
  logic [llfr_pkg::ACC_W-1:0]   acc_digit;
  logic [llfr_pkg::ACC_W-1:0]   fin_acc;
  logic                         do_finish;
  logic [llfr_pkg::SIZE_W-1:0]  shown;
  logic [llfr_pkg::SIZE_W-1:0]  file_dec;
  logic                         res_valid;
  llfr_pkg::result_t            res;

  // ------------------------------------------------------------------
  // Configuration port: always ready; writes beyond the list are dropped.
  // ------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold    <= llfr_pkg::RESET_LIGHT_THRESHOLD;
      end_marker         <= llfr_pkg::RESET_END_MARKER;
      file_marker        <= llfr_pkg::RESET_FILE_MARKER;
      max_message_length <= llfr_pkg::RESET_MAX_MESSAGE_LENGTH;
      size_ceiling       <= llfr_pkg::RESET_SIZE_CEILING;
    end else if (cfg.valid) begin
      case (cfg.index)
        llfr_pkg::REG_LIGHT_THRESHOLD:    light_threshold    <= cfg.data[llfr_pkg::LEVEL_W-1:0];
        llfr_pkg::REG_END_MARKER:         end_marker         <= cfg.data[llfr_pkg::BYTE_W-1:0];
        llfr_pkg::REG_FILE_MARKER:        file_marker        <= cfg.data[llfr_pkg::BYTE_W-1:0];
        llfr_pkg::REG_MAX_MESSAGE_LENGTH: max_message_length <= cfg.data[llfr_pkg::BYTE_W-1:0];
        llfr_pkg::REG_SIZE_CEILING:       size_ceiling       <= cfg.data[llfr_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Sample side: take a beat whenever the skid register is free.
  // ------------------------------------------------------------------
  assign samples.ready = !skid_valid;
  assign sample_fire   = samples.valid && samples.ready;

  // Bit decision and MSB-first assembly of the byte in progress.
  assign sample_bit = (samples.light_level < light_threshold);

  always_comb begin
    shifted          = byte_shift;
    shifted[bit_pos] = byte_shift[bit_pos] | sample_bit;
  end

  // Effective length limit: the tighter of the register and the hard cap.
  assign lim       = (max_message_length > llfr_pkg::MESSAGE_LIMIT) ?
                     llfr_pkg::MESSAGE_LIMIT : max_message_length;
  assign bytes_inc = bytes_so_far + 8'd1;

  // Decimal size digit: acc * 10 + digit, saturating at 65536.
  assign is_digit  = shifted inside {[llfr_pkg::ASCII_ZERO:llfr_pkg::ASCII_NINE]};
  always_comb begin
    logic [19:0] times10;
    logic [llfr_pkg::BYTE_W-1:0] digit;
    digit    = shifted - llfr_pkg::ASCII_ZERO;
    times10  = {size_acc, 3'b000} + {2'b00, size_acc, 1'b0};
    times10  = times10 + {16'd0, digit[3:0]};
    acc_digit = (times10 > {3'b000, llfr_pkg::SIZE_SAT}) ?
                llfr_pkg::SIZE_SAT : times10[llfr_pkg::ACC_W-1:0];
  end

  assign file_dec = file_left - 16'd1;

  // ------------------------------------------------------------------
  // Next state and result for the beat on the sample channel.
  // ------------------------------------------------------------------
  always_comb begin
    mode_next          = mode;
    bit_pos_next       = bit_pos;
    byte_shift_next    = byte_shift;
    bytes_so_far_next  = bytes_so_far;
    digits_active_next = digits_active;
    size_acc_next      = size_acc;
    file_left_next     = file_left;
    res_valid          = 1'b0;
    res.kind           = llfr_pkg::KIND_MSG_BYTE;
    res.data_byte      = '0;
    res.file_size      = '0;
    res.last           = 1'b0;
    do_finish          = 1'b0;
    fin_acc            = size_acc;
    shown              = '0;

    if (sample_fire) begin
      if (samples.action == llfr_pkg::ACTION_START) begin
        // Start: abandon whatever was in progress and clear the frame.
        mode_next          = llfr_pkg::MODE_MESSAGE;
        bit_pos_next       = llfr_pkg::BIT_POS_TOP;
        byte_shift_next    = '0;
        bytes_so_far_next  = '0;
        digits_active_next = 1'b1;
        size_acc_next      = '0;
        file_left_next     = '0;
      end else if (mode != llfr_pkg::MODE_IDLE) begin
        if (bit_pos != 3'd0) begin
          // Mid-byte: store the bit and move to the next position.
          byte_shift_next = shifted;
          bit_pos_next    = bit_pos - 3'd1;
        end else begin
          // Byte complete: rewind the bit counter and act on the byte.
          bit_pos_next    = llfr_pkg::BIT_POS_TOP;
          byte_shift_next = '0;
          case (mode)
            llfr_pkg::MODE_MESSAGE: begin
              if (shifted == end_marker) begin
                mode_next = llfr_pkg::MODE_IDLE;
                res_valid = 1'b1;
                res.kind  = llfr_pkg::KIND_END_MARKER;
              end else if ((bytes_so_far == 8'd0) && (shifted == file_marker)) begin
                // File marker as first byte: switch to header parsing.
                mode_next         = llfr_pkg::MODE_HEADER;
                bytes_so_far_next = 8'd1;
                do_finish         = (8'd1 >= lim);
              end else begin
                bytes_so_far_next = bytes_inc;
                res_valid         = 1'b1;
                res.data_byte     = shifted;
                if (bytes_inc >= lim) begin
                  mode_next = llfr_pkg::MODE_IDLE;
                  res.kind  = llfr_pkg::KIND_END_LIMIT;
                end else begin
                  res.kind  = llfr_pkg::KIND_MSG_BYTE;
                end
              end
            end
            llfr_pkg::MODE_HEADER: begin
              if (shifted == end_marker) begin
                do_finish = 1'b1;
              end else begin
                bytes_so_far_next = bytes_inc;
                if (digits_active && is_digit) begin
                  size_acc_next = acc_digit;
                  fin_acc       = acc_digit;
                end else begin
                  digits_active_next = 1'b0;
                end
                do_finish = (bytes_inc >= lim);
              end
            end
            llfr_pkg::MODE_FILE: begin
              file_left_next = file_dec;
              res_valid      = 1'b1;
              res.kind       = llfr_pkg::KIND_FILE_BYTE;
              res.data_byte  = shifted;
              if (file_dec == 16'd0) begin
                mode_next = llfr_pkg::MODE_IDLE;
                res.last  = 1'b1;
              end
            end
            default: ;
          endcase

          // Close the header: reject if too big, finish on a zero size, else open the file body.
          if (do_finish) begin
            shown     = fin_acc[llfr_pkg::SIZE_W] ? '1 : fin_acc[llfr_pkg::SIZE_W-1:0];
            res_valid = 1'b1;
            mode_next = llfr_pkg::MODE_IDLE;
            if (fin_acc > {1'b0, size_ceiling}) begin
              res.kind      = llfr_pkg::KIND_HDR_REJECTED;
              res.file_size = shown;
            end else if (fin_acc == '0) begin
              res.kind      = llfr_pkg::KIND_HDR_ACCEPTED;
              res.last      = 1'b1;
            end else begin
              mode_next      = llfr_pkg::MODE_FILE;
              file_left_next = fin_acc[llfr_pkg::SIZE_W-1:0];
              res.kind       = llfr_pkg::KIND_HDR_ACCEPTED;
              res.file_size  = shown;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= llfr_pkg::MODE_IDLE;
      bit_pos       <= llfr_pkg::BIT_POS_TOP;
      byte_shift    <= '0;
      bytes_so_far  <= '0;
      digits_active <= 1'b1;
      size_acc      <= '0;
      file_left     <= '0;
    end else begin
      mode          <= mode_next;
      bit_pos       <= bit_pos_next;
      byte_shift    <= byte_shift_next;
      bytes_so_far  <= bytes_so_far_next;
      digits_active <= digits_active_next;
      size_acc      <= size_acc_next;
      file_left     <= file_left_next;
    end
  end

  // ------------------------------------------------------------------
  // Output register with skid: a stalled output beat parks the next
  // result in the skid register; the skid drains first when freed.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !results.ready) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !results.ready) begin
      if (res_valid) begin
        skid_reg <= res;
      end
    end else if (skid_valid) begin
      out_reg <= skid_reg;
    end else begin
      out_reg <= res;
    end
  end

  assign results.valid     = out_valid;
  assign results.kind      = out_reg.kind;
  assign results.data_byte = out_reg.data_byte;
  assign results.file_size = out_reg.file_size;
  assign results.last      = out_reg.last;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`include "light_link_frame_receiver_assert.svh"

  `LLFR_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid,
                    "skid holds a beat with output empty")
  `LLFR_ASSERT_SAME(a_file_count_live, mode == llfr_pkg::MODE_FILE, file_left != 16'd0,
                    "file mode with no bytes left")
  `LLFR_ASSERT_SAME(a_acc_bounded, 1'b1, size_acc <= llfr_pkg::SIZE_SAT,
                    "size accumulator beyond saturation")
  `LLFR_ASSERT_NEXT(a_last_ends_file,
                    res_valid && res.kind == llfr_pkg::KIND_FILE_BYTE && res.last,
                    mode == llfr_pkg::MODE_IDLE, "last file byte left receiver busy")

endmodule
